/* rtl/core/hyp80_pkg.sv */
// Shared types and constants for the binary80 hypotenuse core.
// No dependencies; every other file in rtl/core except hyp80_checker imports this package.
package hyp80_pkg;

  localparam logic [14:0]  EXP_ALL  = 15'h7fff;
  localparam logic [63:0]  TOP_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0]  QUIET    = 64'h4000_0000_0000_0000;
  localparam int           SQRT_STEPS = 64;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_DOWN    = 2'd1,
    RM_UP      = 2'd2,
    RM_ZERO    = 2'd3
  } rmode_t;

  // Everything an item carries beside the square root datapath.
  typedef struct packed {
    logic          special;  // NaN or infinity result, fully formed in sig/ex/sign
    logic          direct;   // finite result decided without the square root
    logic          chk32;    // direct, nearest mode, exponent gap of exactly 32
    logic          d_up;
    logic          d_inx;
    logic [63:0]   sig;
    logic [15:0]   ex;
    logic          sign;
    logic          inv;
    rmode_t        rmode;
    logic [127:0]  frac;     // bits of the radicand below the integer part
  } side_t;

  // Normalized operands, larger magnitude first.
  typedef struct packed {
    logic [63:0]         ms;
    logic [63:0]         ns;
    logic signed [16:0]  me;
    logic [4:0]          gap;
  } op_t;

endpackage

/* rtl/core/hypot_binary80_correctly_rounded_core.sv */
// Correctly rounded hypotenuse of two binary80 operands, fully pipelined.
// One item per cycle, so busy stays low. The depth is set by the 64 root
// cells, one root bit each, plus decode, squaring, alignment, carry fold,
// subnormal scaling and two rounding stages.
// Reset (rst_n low, synchronous) empties the pipeline and sets rounding to
// nearest even. Results cannot be stalled by the receiver.
module hypot_binary80_correctly_rounded_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [63:0]  in_x_significand,
  input  logic [15:0]  in_x_sign_exponent,
  input  logic [63:0]  in_y_significand,
  input  logic [15:0]  in_y_sign_exponent,
  output logic         out_valid,
  output logic [63:0]  out_result_significand,
  output logic [14:0]  out_result_exponent,
  output logic         out_result_sign,
  output logic         out_inexact_flag,
  output logic         out_overflow_flag,
  output logic         out_invalid_flag,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import hyp80_pkg::*;

  rmode_t rmode_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = {30'd0, rmode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmode_r <= RM_NEAREST;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      rmode_r <= rmode_t'(pwdata[1:0]);
    end
  end

  logic  fr_v;
  side_t fr_side;
  op_t   fr_op;

  hyp80_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (start && !busy),
    .x_sig  (in_x_significand),
    .x_se   (in_x_sign_exponent),
    .y_sig  (in_y_significand),
    .y_se   (in_y_sign_exponent),
    .rmode  (rmode_r),
    .v_r    (fr_v),
    .side_r (fr_side),
    .op_r   (fr_op)
  );

  logic         cv    [0:SQRT_STEPS];
  logic [127:0] crad  [0:SQRT_STEPS];
  logic [65:0]  cacc  [0:SQRT_STEPS];
  logic [63:0]  cq    [0:SQRT_STEPS];
  side_t        cside [0:SQRT_STEPS];

  hyp80_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (fr_v),
    .in_side (fr_side),
    .in_op   (fr_op),
    .v_r     (cv[0]),
    .top_r   (crad[0]),
    .side_r  (cside[0])
  );

  assign cacc[0] = '0;
  assign cq[0]   = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
    hyp80_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_v    (cv[g]),
      .in_rad  (crad[g]),
      .in_acc  (cacc[g]),
      .in_q    (cq[g]),
      .in_side (cside[g]),
      .v_r     (cv[g+1]),
      .rad_r   (crad[g+1]),
      .acc_r   (cacc[g+1]),
      .q_r     (cq[g+1]),
      .side_r  (cside[g+1])
    );
  end

  hyp80_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (cv[SQRT_STEPS]),
    .root    (cq[SQRT_STEPS]),
    .rest    (cacc[SQRT_STEPS]),
    .in_side (cside[SQRT_STEPS]),
    .out_v_r (out_valid),
    .sig_r   (out_result_significand),
    .ex_r    (out_result_exponent),
    .sign_r  (out_result_sign),
    .inx_r   (out_inexact_flag),
    .ovf_r   (out_overflow_flag),
    .inv_r   (out_invalid_flag)
  );

endmodule

/* rtl/core/hyp80_front.sv */
// Input decode: NaN and infinity resolution, normalization, ordering and
// the cases decided without a square root. Uses hyp80_pkg.
module hyp80_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  logic [63:0]          x_sig,
  input  logic [15:0]          x_se,
  input  logic [63:0]          y_sig,
  input  logic [15:0]          y_se,
  input  hyp80_pkg::rmode_t    rmode,
  output logic                 v_r,
  output hyp80_pkg::side_t     side_r,
  output hyp80_pkg::op_t       op_r
);
  import hyp80_pkg::*;

  function automatic logic [6:0] lzc64(input logic [63:0] s);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (s[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  logic [14:0] ae, be, pe, qe;
  logic [63:0] pm, qm, sp_sig;
  logic        psg, qsg, an, bn, sp_sign, sp_inv, swap_s;
  logic        za, zb, swap_n, nzero;
  logic [6:0]  lza, lzb;
  logic [63:0] ma, mb, mm, nm, den;
  logic signed [16:0] ea, eb, me, ne, gap, dsh;
  logic [15:0] dex;
  side_t       side_nxt;
  op_t         op_nxt;

  always_comb begin
    ae = x_se[14:0];
    be = y_se[14:0];
    // NaN and infinity handling orders by exponent, then significand.
    swap_s = (ae < be) || (ae == be && x_sig < y_sig);
    pm  = swap_s ? y_sig : x_sig;
    pe  = swap_s ? be : ae;
    psg = swap_s ? y_se[15] : x_se[15];
    qm  = swap_s ? x_sig : y_sig;
    qe  = swap_s ? ae : be;
    qsg = swap_s ? x_se[15] : y_se[15];
    an  = (pe == EXP_ALL) && (pm[62:0] != 63'd0);
    bn  = (qe == EXP_ALL) && (qm[62:0] != 63'd0);
    sp_sig  = TOP_BIT;
    sp_sign = 1'b0;
    sp_inv  = 1'b0;
    if ((an && !pm[62]) || (bn && !qm[62])) begin
      sp_inv = 1'b1;
      if (an) begin
        sp_sig  = pm | TOP_BIT | QUIET;
        sp_sign = psg;
      end else begin
        sp_sig  = qm | TOP_BIT | QUIET;
        sp_sign = qsg;
      end
    end else if (an && bn) begin
      sp_sig  = pm;
      sp_sign = psg;
    end else if ((an || bn) && !(pe == EXP_ALL && qe == EXP_ALL)) begin
      sp_sig  = an ? pm : qm;
      sp_sign = an ? psg : qsg;
    end

    za  = (x_sig == 64'd0);
    zb  = (y_sig == 64'd0);
    lza = lzc64(x_sig);
    lzb = lzc64(y_sig);
    ma  = x_sig << lza;
    mb  = y_sig << lzb;
    ea  = $signed({2'b00, (ae == 15'd0) ? 15'd1 : ae}) - $signed({10'd0, lza});
    eb  = $signed({2'b00, (be == 15'd0) ? 15'd1 : be}) - $signed({10'd0, lzb});
    swap_n = za || (!zb && (eb > ea || (eb == ea && mb > ma)));
    mm    = swap_n ? mb : ma;
    me    = swap_n ? eb : ea;
    nm    = swap_n ? ma : mb;
    ne    = swap_n ? ea : eb;
    nzero = swap_n ? za : zb;
    gap   = me - ne;
    dsh   = 17'sd1 - me;
    den   = (me >= 17'sd1) ? mm : (mm >> dsh[5:0]);
    dex   = (me < 17'sd1) ? 16'd0 : me[15:0];

    side_nxt       = '0;
    side_nxt.rmode = rmode;
    if (ae == EXP_ALL || be == EXP_ALL) begin
      side_nxt.special = 1'b1;
      side_nxt.sig     = sp_sig;
      side_nxt.ex      = {1'b0, EXP_ALL};
      side_nxt.sign    = sp_sign;
      side_nxt.inv     = sp_inv;
    end else if (za && zb) begin
      side_nxt.direct = 1'b1;
    end else if (nzero) begin
      side_nxt.direct = 1'b1;
      side_nxt.sig    = den;
      side_nxt.ex     = dex;
    end else if (gap >= 17'sd32) begin
      // The smaller operand only decides the rounding direction.
      side_nxt.direct = 1'b1;
      side_nxt.sig    = den;
      side_nxt.ex     = dex;
      side_nxt.d_up   = (rmode == RM_UP);
      side_nxt.d_inx  = 1'b1;
      side_nxt.chk32  = (me >= 17'sd1) && (rmode == RM_NEAREST) && (gap == 17'sd32);
    end

    op_nxt.ms  = mm;
    op_nxt.ns  = nm;
    op_nxt.me  = me;
    op_nxt.gap = gap[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
    op_r   <= op_nxt;
  end

endmodule

/* rtl/core/hyp80_prep.sv */
// Radicand preparation: squares from 32-bit partial products, aligned sum
// with fraction, carry renormalization and subnormal scaling. Uses hyp80_pkg.
module hyp80_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  hyp80_pkg::side_t     in_side,
  input  hyp80_pkg::op_t       in_op,
  output logic                 v_r,
  output logic [127:0]         top_r,
  output hyp80_pkg::side_t     side_r
);
  import hyp80_pkg::*;

  // Stage 2: partial products of both squares.
  logic [63:0]  a00_r, a01_r, a11_r, b00_r, b01_r, b11_r;
  logic [63:0]  ms2_r;
  logic [4:0]   gap2_r;
  logic signed [16:0] me2_r;
  side_t        side2_r;
  // Stage 3: full squares.
  logic [127:0] asq3_r, bsq3_r;
  logic [63:0]  ms3_r;
  logic [4:0]   gap3_r;
  logic signed [16:0] me3_r;
  side_t        side3_r;
  // Stage 4: aligned smaller square.
  logic [127:0] asq4_r, bsh4_r, fr4_r;
  logic signed [16:0] me4_r;
  side_t        side4_r;
  // Stage 5: sum with carry folded back.
  logic [127:0] top5_r, frac5_r;
  logic signed [16:0] me5_r;
  side_t        side5_r;
  logic [4:0]   v_sh_r;

  logic [127:0] asq_nxt, bsq_nxt, bsh_nxt, fr_nxt, top5_nxt, frac5_nxt;
  logic [128:0] sum5;
  logic [6:0]   flsh;
  logic         up32;
  side_t        side4_nxt, side6_nxt;
  logic signed [16:0] me5_nxt, sh6;
  logic [255:0] tf6;
  logic [127:0] top6_nxt;

  always_comb begin
    asq_nxt = {a11_r, 64'd0} + ({64'd0, a01_r} << 33) + {64'd0, a00_r};
    bsq_nxt = {b11_r, 64'd0} + ({64'd0, b01_r} << 33) + {64'd0, b00_r};

    bsh_nxt = bsq3_r >> {gap3_r, 1'b0};
    flsh    = 7'd0 - {1'b0, gap3_r, 1'b0};
    fr_nxt  = (gap3_r == 5'd0) ? 128'd0 : (bsq3_r << flsh);
    up32    = (bsq3_r[127:64] > ms3_r) ||
              (bsq3_r[127:64] == ms3_r && bsq3_r[63:0] > QUIET);
    side4_nxt = side3_r;
    if (side3_r.chk32) side4_nxt.d_up = up32;

    sum5 = {1'b0, asq4_r} + {1'b0, bsh4_r};
    if (sum5[128]) begin
      top5_nxt  = {2'b01, sum5[127:2]};
      frac5_nxt = {sum5[1:0], fr4_r[127:2]};
      me5_nxt   = me4_r + 17'sd1;
    end else begin
      top5_nxt  = sum5[127:0];
      frac5_nxt = fr4_r;
      me5_nxt   = me4_r;
    end

    // Subnormal result: shift the radicand by an even amount.
    sh6       = 17'sd1 - me5_r;
    tf6       = {top5_r, frac5_r} >> {sh6[5:0], 1'b0};
    side6_nxt = side5_r;
    top6_nxt  = top5_r;
    if (!side5_r.special && !side5_r.direct) begin
      if (me5_r < 17'sd1) begin
        top6_nxt       = tf6[255:128];
        side6_nxt.frac = tf6[127:0];
        side6_nxt.ex   = 16'd0;
      end else begin
        side6_nxt.frac = frac5_r;
        side6_nxt.ex   = me5_r[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sh_r <= '0;
    end else begin
      v_sh_r <= {v_sh_r[3:0], in_v};
    end
  end
  assign v_r = v_sh_r[4];

  always_ff @(posedge clk) begin
    a00_r   <= {32'd0, in_op.ms[31:0]} * {32'd0, in_op.ms[31:0]};
    a01_r   <= {32'd0, in_op.ms[31:0]} * {32'd0, in_op.ms[63:32]};
    a11_r   <= {32'd0, in_op.ms[63:32]} * {32'd0, in_op.ms[63:32]};
    b00_r   <= {32'd0, in_op.ns[31:0]} * {32'd0, in_op.ns[31:0]};
    b01_r   <= {32'd0, in_op.ns[31:0]} * {32'd0, in_op.ns[63:32]};
    b11_r   <= {32'd0, in_op.ns[63:32]} * {32'd0, in_op.ns[63:32]};
    ms2_r   <= in_op.ms;
    gap2_r  <= in_op.gap;
    me2_r   <= in_op.me;
    side2_r <= in_side;

    asq3_r  <= asq_nxt;
    bsq3_r  <= bsq_nxt;
    ms3_r   <= ms2_r;
    gap3_r  <= gap2_r;
    me3_r   <= me2_r;
    side3_r <= side2_r;

    asq4_r  <= asq3_r;
    bsh4_r  <= bsh_nxt;
    fr4_r   <= fr_nxt;
    me4_r   <= me3_r;
    side4_r <= side4_nxt;

    top5_r  <= top5_nxt;
    frac5_r <= frac5_nxt;
    me5_r   <= me5_nxt;
    side5_r <= side4_r;

    top_r   <= top6_nxt;
    side_r  <= side6_nxt;
  end

endmodule

/* rtl/core/hyp80_sqrt_cell.sv */
// One step of the restoring square root: takes the next radicand bit pair,
// produces one root bit and hands the partial state on. Uses hyp80_pkg.
module hyp80_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  logic [127:0]         in_rad,
  input  logic [65:0]          in_acc,
  input  logic [63:0]          in_q,
  input  hyp80_pkg::side_t     in_side,
  output logic                 v_r,
  output logic [127:0]         rad_r,
  output logic [65:0]          acc_r,
  output logic [63:0]          q_r,
  output hyp80_pkg::side_t     side_r
);
  import hyp80_pkg::*;

  logic [67:0] accx, trial, diff;
  logic        ge;

  always_comb begin
    accx  = {in_acc, in_rad[127:126]};
    trial = {2'b00, in_q, 2'b01};
    ge    = (accx >= trial);
    diff  = accx - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= {in_rad[125:0], 2'b00};
    acc_r  <= ge ? diff[65:0] : accx[65:0];
    q_r    <= {in_q[62:0], ge};
    side_r <= in_side;
  end

endmodule

/* rtl/core/hyp80_round.sv */
// Rounding decision from root, remainder and fraction, then increment,
// canonical exponent and overflow handling into the result register.
// Uses hyp80_pkg.
module hyp80_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  logic [63:0]          root,
  input  logic [65:0]          rest,
  input  hyp80_pkg::side_t     in_side,
  output logic                 out_v_r,
  output logic [63:0]          sig_r,
  output logic [14:0]          ex_r,
  output logic                 sign_r,
  output logic                 inx_r,
  output logic                 ovf_r,
  output logic                 inv_r
);
  import hyp80_pkg::*;

  logic        v1_r, spec1_r, up1_r, inx1_r, sign1_r, inv1_r;
  logic [63:0] sig1_r;
  logic [15:0] ex1_r;
  rmode_t      rm1_r;

  logic        c_gt, c_eq, f_gt, f_eq, whole, up_sq, up_nxt, inx_nxt;
  logic [64:0] inc;
  logic [63:0] fsig;
  logic [15:0] fex;

  always_comb begin
    c_gt  = rest > {2'b00, root};
    c_eq  = rest == {2'b00, root};
    f_gt  = in_side.frac > {QUIET, 64'd0};
    f_eq  = in_side.frac == {QUIET, 64'd0};
    whole = (rest == 66'd0) && (in_side.frac == 128'd0);
    unique case (in_side.rmode)
      RM_NEAREST: up_sq = c_gt || (c_eq && (f_gt || (f_eq && root[0])));
      RM_UP:      up_sq = !whole;
      RM_DOWN:    up_sq = 1'b0;
      RM_ZERO:    up_sq = 1'b0;
    endcase
    up_nxt  = in_side.direct ? in_side.d_up : up_sq;
    inx_nxt = in_side.direct ? in_side.d_inx : !whole;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      v1_r    <= in_v;
      out_v_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    spec1_r <= in_side.special;
    sig1_r  <= (in_side.special || in_side.direct) ? in_side.sig : root;
    ex1_r   <= in_side.ex;
    sign1_r <= in_side.sign;
    inv1_r  <= in_side.inv;
    up1_r   <= up_nxt && !in_side.special;
    inx1_r  <= inx_nxt && !in_side.special;
    rm1_r   <= in_side.rmode;
  end

  always_comb begin
    inc  = {1'b0, sig1_r} + {64'd0, up1_r};
    fsig = sig1_r;
    fex  = ex1_r;
    if (up1_r) begin
      fsig = inc[63:0];
      if (inc[64]) begin
        fsig = TOP_BIT;
        fex  = ex1_r + 16'd1;
      end else if (ex1_r == 16'd0 && inc[63]) begin
        // A subnormal that rounds up to the smallest normal.
        fex = 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (spec1_r) begin
      sig_r  <= sig1_r;
      ex_r   <= ex1_r[14:0];
      sign_r <= sign1_r;
      inx_r  <= 1'b0;
      ovf_r  <= 1'b0;
      inv_r  <= inv1_r;
    end else if (fex >= {1'b0, EXP_ALL}) begin
      if (rm1_r == RM_NEAREST || rm1_r == RM_UP) begin
        sig_r <= TOP_BIT;
        ex_r  <= EXP_ALL;
      end else begin
        sig_r <= '1;
        ex_r  <= EXP_ALL - 15'd1;
      end
      sign_r <= 1'b0;
      inx_r  <= 1'b1;
      ovf_r  <= 1'b1;
      inv_r  <= 1'b0;
    end else begin
      sig_r  <= fsig;
      ex_r   <= fex[14:0];
      sign_r <= 1'b0;
      inx_r  <= inx1_r;
      ovf_r  <= 1'b0;
      inv_r  <= 1'b0;
    end
  end

endmodule

/* rtl/core/hyp80_checker.sv */
// Port-level checks for the hypotenuse core, bound to the top level.
// Depends only on the top level's ports.
module hyp80_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         busy,
  input  logic         out_valid,
  input  logic [63:0]  out_result_significand,
  input  logic [14:0]  out_result_exponent,
  input  logic         out_result_sign,
  input  logic         out_inexact_flag,
  input  logic         out_overflow_flag,
  input  logic         out_invalid_flag
);

  // The pipeline takes an item every cycle.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_ovf_inexact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_flag |-> out_inexact_flag && !out_invalid_flag)
    else $error("overflow without inexact");

  a_inv_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_flag |->
      out_result_exponent == 15'h7fff && out_result_significand[63:62] == 2'b11)
    else $error("invalid result is not a quiet NaN");

  // Only a propagated NaN may carry a sign.
  a_sign_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_sign |-> out_result_exponent == 15'h7fff &&
      !out_inexact_flag)
    else $error("signed non-NaN result");

  a_canonical: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_exponent == 15'd0 |-> !out_result_significand[63])
    else $error("non-canonical subnormal");

endmodule

bind hypot_binary80_correctly_rounded_core hyp80_checker u_hyp80_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the binary80 hypotenuse core.
// Depends on hyp80_pkg and hypot_binary80_correctly_rounded_core from rtl/core.
module tb_top;
  import hyp80_pkg::*;

  typedef struct {
    logic [63:0] sig;
    logic [14:0] ex;
    logic        sign;
    logic        inx;
    logic        ovf;
    logic        inv;
  } hyp_res_t;

  typedef struct {
    logic [63:0] xs;
    logic [15:0] xw;
    logic [63:0] ys;
    logic [15:0] yw;
    logic        known;
    hyp_res_t    res;
  } stim_row_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 90;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_x_significand = '0;
  logic [15:0] in_x_sign_exponent = '0;
  logic [63:0] in_y_significand = '0;
  logic [15:0] in_y_sign_exponent = '0;
  logic        out_valid;
  logic [63:0] out_result_significand;
  logic [14:0] out_result_exponent;
  logic        out_result_sign;
  logic        out_inexact_flag;
  logic        out_overflow_flag;
  logic        out_invalid_flag;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hyp_res_t  pending_results[$];
  stim_row_t dir_rows[$];
  rmode_t    cur_mode = RM_NEAREST;
  int        err_count = 0;
  int        cycle_count = 0;

  hypot_binary80_correctly_rounded_core i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hyp_res_t mk_res(logic [63:0] sig, logic [14:0] ex, logic sign,
                                      logic inx, logic ovf, logic inv);
    hyp_res_t r;
    r.sig = sig; r.ex = ex; r.sign = sign; r.inx = inx; r.ovf = ovf; r.inv = inv;
    return r;
  endfunction

  // Final increment, renormalization and overflow handling.
  function automatic hyp_res_t round_out(logic [63:0] sig, int ex, logic up, logic inx,
                                         rmode_t rm);
    if (up) begin
      sig++;
      if (sig == 0) begin
        sig = TOP_BIT;
        ex++;
      end else if (ex == 0 && sig[63]) begin
        ex = 1;
      end
    end
    if (ex >= int'(EXP_ALL)) begin
      if (rm == RM_NEAREST || rm == RM_UP) return mk_res(TOP_BIT, EXP_ALL, 0, 1, 1, 0);
      return mk_res('1, EXP_ALL - 15'd1, 0, 1, 1, 0);
    end
    return mk_res(sig, ex[14:0], 0, inx, 0, 0);
  endfunction

  function automatic logic [63:0] subnormal_sig(logic [63:0] sig, int ex);
    int sh;
    if (ex >= 1) return sig;
    sh = 1 - ex;
    return (sh >= 64) ? 64'd0 : sig >> sh;
  endfunction

  function automatic hyp_res_t hypot_predict(logic [63:0] am, logic [15:0] aw,
                                             logic [63:0] bm, logic [15:0] bw, rmode_t rm);
    logic [14:0]  ae, be;
    logic [63:0]  tm, ms, ns, root;
    logic [15:0]  tw;
    logic         an, bn, mz, nz, up, whole, tz;
    logic [127:0] asq, bsq, top, frac, half;
    logic [129:0] acc, trial;
    int           me, ne, te, gap, sh;
    half = {QUIET, 64'd0};
    ae = aw[14:0];
    be = bw[14:0];
    if (ae == EXP_ALL || be == EXP_ALL) begin
      if (ae < be || (ae == be && am < bm)) begin
        tm = am; tw = aw; am = bm; aw = bw; bm = tm; bw = tw;
        ae = aw[14:0]; be = bw[14:0];
      end
      an = (ae == EXP_ALL) && (am[62:0] != 0);
      bn = (be == EXP_ALL) && (bm[62:0] != 0);
      if ((an && !am[62]) || (bn && !bm[62])) begin
        if (an) return mk_res(am | TOP_BIT | QUIET, EXP_ALL, aw[15], 0, 0, 1);
        return mk_res(bm | TOP_BIT | QUIET, EXP_ALL, bw[15], 0, 0, 1);
      end
      if (an && bn) return mk_res(am, EXP_ALL, aw[15], 0, 0, 0);
      if ((an || bn) && !(ae == EXP_ALL && be == EXP_ALL)) begin
        if (an) return mk_res(am, EXP_ALL, aw[15], 0, 0, 0);
        return mk_res(bm, EXP_ALL, bw[15], 0, 0, 0);
      end
      return mk_res(TOP_BIT, EXP_ALL, 0, 0, 0, 0);
    end

    // Normalize both operands by value.
    ms = am; me = (ae != 0) ? int'(ae) : 1; mz = (am == 0);
    ns = bm; ne = (be != 0) ? int'(be) : 1; nz = (bm == 0);
    if (mz) me = 0;
    else while (!ms[63]) begin ms = ms << 1; me--; end
    if (nz) ne = 0;
    else while (!ns[63]) begin ns = ns << 1; ne--; end
    if (mz && nz) return mk_res(0, 0, 0, 0, 0, 0);
    if (mz || (!nz && (ne > me || (ne == me && ns > ms)))) begin
      tm = ms; te = me; tz = mz;
      ms = ns; me = ne; mz = nz; ns = tm; ne = te; nz = tz;
    end
    if (nz) return round_out(subnormal_sig(ms, me), (me < 1) ? 0 : me, 0, 0, rm);

    gap = me - ne;
    if (gap >= 32) begin
      up = (rm == RM_UP);
      // At a gap of exactly 32 the small square can push past the halfway point.
      if (me >= 1 && rm == RM_NEAREST && gap == 32) begin
        bsq = ns * ns;
        up = (bsq[127:64] > ms) || (bsq[127:64] == ms && bsq[63:0] > QUIET);
      end
      return round_out(subnormal_sig(ms, me), (me < 1) ? 0 : me, up, 1, rm);
    end

    asq = ms * ms;
    bsq = ns * ns;
    top = asq + (bsq >> (2 * gap));
    frac = (gap != 0) ? bsq << (128 - 2 * gap) : 128'd0;
    if (top < asq) begin
      frac = (top << 126) | (frac >> 2);
      top = half | (top >> 2);
      me++;
    end
    if (me < 1) begin
      sh = 1 - me;
      if (sh > 63) sh = 63;
      frac = (top << (128 - 2 * sh)) | (frac >> (2 * sh));
      top = top >> (2 * sh);
      me = 0;
    end
    acc = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = {acc[127:0], top[2*i+1 -: 2]};
      trial = {64'd0, root, 2'b01};
      if (acc >= trial) begin
        acc = acc - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    whole = (acc == 0) && (frac == 0);
    up = 1'b0;
    if (rm == RM_NEAREST)
      up = (acc > {66'd0, root}) ||
           (acc == {66'd0, root} && (frac > half || (frac == half && root[0])));
    else if (rm == RM_UP)
      up = !whole;
    return round_out(root, me, up, !whole, rm);
  endfunction

  function automatic void add_row(logic [63:0] xs, logic [15:0] xw, logic [63:0] ys,
                                  logic [15:0] yw, logic known, hyp_res_t res);
    stim_row_t r;
    r.xs = xs; r.xw = xw; r.ys = ys; r.yw = yw; r.known = known; r.res = res;
    dir_rows.push_back(r);
  endfunction

  task automatic send_item(stim_row_t r);
    start              <= 1'b1;
    in_x_significand   <= r.xs;
    in_x_sign_exponent <= r.xw;
    in_y_significand   <= r.ys;
    in_y_sign_exponent <= r.yw;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(r.known ? r.res :
                              hypot_predict(r.xs, r.xw, r.ys, r.yw, cur_mode));
  endtask

  task automatic maybe_idle(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(rmode_t rm);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'd0;
    pwdata  <= {30'd0, rm};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = rm;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t   r;
    int          kind, xe, ye, sel;
    logic [63:0] sp;
    kind = $urandom_range(99);
    r.xs = rand64();
    r.ys = rand64();
    r.known = 1'b0;
    r.res = mk_res(0, 0, 0, 0, 0, 0);
    if (kind < 60) begin
      // Close exponents: the square root path, plus the gaps around 32.
      xe = $urandom_range(1, 32766);
      ye = xe + int'($urandom_range(0, 68)) - 34;
      if (ye < 0) ye = 0;
      if (ye > 32766) ye = 32766;
      if ($urandom_range(9) != 0) r.xs[63] = 1'b1;
      if ($urandom_range(9) != 0) r.ys[63] = 1'b1;
    end else if (kind < 72) begin
      xe = $urandom_range(0, 70);
      ye = $urandom_range(0, 70);
      if ($urandom_range(1)) r.xs = r.xs >> $urandom_range(0, 63);
    end else if (kind < 84) begin
      xe = $urandom_range(32700, 32766);
      ye = $urandom_range(32700, 32766);
      r.xs[63] = 1'b1;
      if ($urandom_range(1)) r.xs = r.xs | 64'hffff_fff0_0000_0000;
    end else if (kind < 92) begin
      xe = EXP_ALL;
      ye = $urandom_range(1) ? int'(EXP_ALL) : int'($urandom_range(0, 32766));
      sel = $urandom_range(3);
      sp = r.xs;
      if (sel == 0) sp = {1'($urandom_range(1)), 63'd0};
      else if (sel == 1) sp[62] = 1'b1;
      else if (sel == 2) begin sp[62] = 1'b0; sp[0] = 1'b1; end
      r.xs = sp;
      if ($urandom_range(1)) begin
        sp = r.xs; r.xs = r.ys; r.ys = sp;
        sel = xe; xe = ye; ye = sel;
      end
    end else begin
      xe = $urandom_range(0, 32767);
      ye = $urandom_range(0, 32767);
    end
    r.xw = {1'($urandom_range(1)), 15'(xe)};
    r.yw = {1'($urandom_range(1)), 15'(ye)};
    return r;
  endfunction

  // Results cannot be held off, so every strobe is checked at its edge.
  always @(posedge clk) begin
    hyp_res_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_result_significand !== e.sig) begin
          $error("result_significand exp %h got %h", e.sig, out_result_significand);
          err_count++;
        end
        if (out_result_exponent !== e.ex) begin
          $error("result_exponent exp %h got %h", e.ex, out_result_exponent);
          err_count++;
        end
        if (out_result_sign !== e.sign) begin
          $error("result_sign exp %b got %b", e.sign, out_result_sign);
          err_count++;
        end
        if (out_inexact_flag !== e.inx) begin
          $error("inexact_flag exp %b got %b", e.inx, out_inexact_flag);
          err_count++;
        end
        if (out_overflow_flag !== e.ovf) begin
          $error("overflow_flag exp %b got %b", e.ovf, out_overflow_flag);
          err_count++;
        end
        if (out_invalid_flag !== e.inv) begin
          $error("invalid_flag exp %b got %b", e.inv, out_invalid_flag);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rmode_t    modes[5] = '{RM_NEAREST, RM_DOWN, RM_UP, RM_ZERO, RM_NEAREST};
    int        idles[5] = '{0, 61, 25, 61, 25};
    hyp_res_t  none;
    none = mk_res(0, 0, 0, 0, 0, 0);

    // Directed rows, run in nearest-even mode straight after reset.
    add_row(0, 16'h0000, 0, 16'h8000, 1, mk_res(0, 0, 0, 0, 0, 0));
    add_row(64'hc000_0000_0000_0000, 16'h4000, TOP_BIT, 16'hc001, 1,
            mk_res(64'ha000_0000_0000_0000, 15'h4001, 0, 0, 0, 0));
    add_row(0, 16'h0000, 64'hdead_beef_0000_0001, 16'hb123, 1,
            mk_res(64'hdead_beef_0000_0001, 15'h3123, 0, 0, 0, 0));
    add_row(TOP_BIT, 16'hffff, TOP_BIT, 16'h3fff, 1, mk_res(TOP_BIT, EXP_ALL, 0, 0, 0, 0));
    add_row(64'h0, 16'h7fff, 64'h1234, 16'h0005, 1, mk_res(TOP_BIT, EXP_ALL, 0, 0, 0, 0));
    add_row(64'h8000_0000_0000_0001, 16'hffff, TOP_BIT, 16'h3fff, 1,
            mk_res(64'hc000_0000_0000_0001, EXP_ALL, 1, 0, 0, 1));
    add_row(64'hc000_0000_0000_0001, 16'h7fff, 64'h8000_0000_0000_0002, 16'hffff, 1,
            mk_res(64'hc000_0000_0000_0001, EXP_ALL, 0, 0, 0, 1));
    add_row(64'hc000_0000_0000_0005, 16'h7fff, 64'hc000_0000_0000_0009, 16'hffff, 1,
            mk_res(64'hc000_0000_0000_0009, EXP_ALL, 1, 0, 0, 0));
    add_row(64'hc000_0000_0000_0005, 16'hffff, 64'hc000_0000_0000_0005, 16'h7fff, 1,
            mk_res(64'hc000_0000_0000_0005, EXP_ALL, 1, 0, 0, 0));
    add_row(64'hc000_0000_0000_0007, 16'hffff, 64'h1, 16'h0000, 1,
            mk_res(64'hc000_0000_0000_0007, EXP_ALL, 1, 0, 0, 0));
    add_row(64'hc000_0000_0000_0007, 16'hffff, TOP_BIT, 16'h7fff, 1,
            mk_res(TOP_BIT, EXP_ALL, 0, 0, 0, 0));
    add_row('1, 16'h7ffe, '1, 16'hfffe, 1, mk_res(TOP_BIT, EXP_ALL, 0, 1, 1, 0));
    add_row(64'h1, 16'h0000, 64'h1, 16'h8000, 0, none);
    add_row('1, 16'h0000, '1, 16'h0000, 0, none);
    add_row(64'h1, 16'h0000, 0, 16'h0000, 0, none);
    add_row('1, 16'h3fff, '1, 16'h3fdf, 0, none);
    add_row(TOP_BIT, 16'h3fff, '1, 16'h3fdf, 0, none);
    add_row('1, 16'h3fff, '1, 16'h3fe0, 0, none);
    add_row(64'h0000_0001_0000_0000, 16'h4010, TOP_BIT, 16'h0001, 0, none);
    add_row(64'h8000_0000_0000_0000, 16'h0000, 64'h4000_0000_0000_0000, 16'h0000, 0, none);
    add_row('1, 16'h7ffe, 64'h1, 16'h0000, 0, none);
    add_row(64'hb504_f333_f9de_6484, 16'h7ffe, 64'hb504_f333_f9de_6484, 16'h7ffe, 0, none);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i]);
      maybe_idle(30);
    end
    drain_results();

    for (int p = 0; p < 5; p++) begin
      write_mode(modes[p]);
      for (int n = 0; n < 140; n++) begin
        send_item(random_row());
        if (n == 70) drain_results();
        else maybe_idle(idles[p]);
      end
      drain_results();
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/hyp80_pkg.sv
rtl/core/hyp80_front.sv
rtl/core/hyp80_prep.sv
rtl/core/hyp80_sqrt_cell.sv
rtl/core/hyp80_round.sv
rtl/core/hypot_binary80_correctly_rounded_core.sv
rtl/core/hyp80_checker.sv
dv/tb_top.sv
